// File: rtl/adcevu_pkg.sv
package adcevu_pkg;

	// default sizes of the block
	localparam int unsigned MAX_HITS_DEF        = 48;
	localparam int unsigned NUM_CHANNELS_DEF    = 16;
	localparam int unsigned NUM_BINS_DEF        = 4096;
	localparam int unsigned BIN_COUNT_WIDTH_DEF = 32;

	// readout word layout
	localparam int unsigned LEN_W    = 13;
	localparam int unsigned VAL_W    = 12;
	localparam int unsigned CHAN_LSB = 17;
	localparam int unsigned CHAN_W   = 4;
	localparam int unsigned TAG_LSB  = 21;
	localparam int unsigned TAG_W    = 6;

	// result field widths
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned SLOT_W   = 6;
	localparam int unsigned TOTAL_W  = 32;

	// kind of each word in the result
	typedef enum logic [KIND_W-1:0] {
		KIND_BLOCK_HDR  = 3'd0,
		KIND_MODULE_HDR = 3'd1,
		KIND_HIT        = 3'd2,
		KIND_NON_HIT    = 3'd3,
		KIND_BROKEN     = 3'd4
	} word_kind_t;

endpackage

// File: rtl/adc_event_word_unpacker.sv
// Stage 1 holds the bin read in flight; the stage 2 register drives res_valid. One word per
// cycle unless res_ready holds stage 2 or the clear runs; the histogram read-modify-write is
// a registered memory read then a write-back, with forwarding for back-to-back hits on one
// bin. Reset: control state clears at once; then a clearing pass zeroes the histogram's
// NUM_CHANNELS*NUM_BINS bins (65536 by default), with word_ready low throughout.
module adc_event_word_unpacker #(
	parameter int unsigned MAX_HITS        = adcevu_pkg::MAX_HITS_DEF,
	parameter int unsigned NUM_CHANNELS    = adcevu_pkg::NUM_CHANNELS_DEF,
	parameter int unsigned NUM_BINS        = adcevu_pkg::NUM_BINS_DEF,
	parameter int unsigned BIN_COUNT_WIDTH = adcevu_pkg::BIN_COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	output logic        word_ready,
	input  logic [31:0] word,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  word_kind,
	output logic [3:0]  hit_channel,
	output logic [11:0] hit_value,
	output logic [5:0]  hit_slot,
	output logic [5:0]  hit_count,
	output logic [31:0] bin_count,
	output logic [31:0] broken_total,
	output logic        event_done
);
	import adcevu_pkg::*;

	localparam int unsigned HIST_DEPTH = NUM_CHANNELS * NUM_BINS;
	localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
	localparam int unsigned CNT_W      = $clog2(MAX_HITS);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_HITS - 1);
	localparam logic [BIN_COUNT_WIDTH-1:0] BIN_MAX = '1;
	localparam logic [HIST_AW-1:0] CLR_LAST = HIST_AW'(HIST_DEPTH - 1);

	typedef enum logic [1:0] {
		PH_BLOCK  = 2'd0,
		PH_MODULE = 2'd1,
		PH_DATA   = 2'd2,
		PH_BROKEN = 2'd3
	} phase_t;

	// histogram memory
	logic [BIN_COUNT_WIDTH-1:0] hist_mem [HIST_DEPTH];

	// control state
	phase_t             phase_q;
	logic [LEN_W-1:0]   words_left_q;
	logic [CNT_W-1:0]   mult_q;
	logic [TOTAL_W-1:0] broken_q;
	logic               clr_active_q;
	logic [HIST_AW-1:0] clr_addr_q;

	// stage 1: bin read in flight
	logic                       valid_s1;
	word_kind_t                 kind_s1;
	logic [CHAN_W-1:0]          chan_s1;
	logic [VAL_W-1:0]           val_s1;
	logic [SLOT_W-1:0]          slot_s1;
	logic [SLOT_W-1:0]          cnt_s1;
	logic [TOTAL_W-1:0]         broken_s1;
	logic                       done_s1;
	logic                       upd_s1;
	logic [HIST_AW-1:0]         addr_s1;
	logic                       fwd_s1;
	logic [BIN_COUNT_WIDTH-1:0] fwd_data_s1;
	logic [BIN_COUNT_WIDTH-1:0] rd_data_s1;

	// stage 2: result register
	logic               valid_s2;
	word_kind_t         kind_s2;
	logic [CHAN_W-1:0]  chan_s2;
	logic [VAL_W-1:0]   val_s2;
	logic [SLOT_W-1:0]  slot_s2;
	logic [SLOT_W-1:0]  cnt_s2;
	logic [31:0]        bin_s2;
	logic [TOTAL_W-1:0] broken_s2;
	logic               done_s2;

	// handshake
	logic accept;
	logic adv_s1;

	assign adv_s1     = valid_s1 && (!valid_s2 || res_ready);
	assign word_ready = !clr_active_q && (!valid_s1 || adv_s1);
	assign accept     = word_valid && word_ready;

	// word decode
	logic [LEN_W-1:0]   len;
	logic [CHAN_W-1:0]  w_chan;
	logic [VAL_W-1:0]   w_val;
	logic               w_is_hit;
	logic               w_in_range;
	logic [HIST_AW-1:0] rd_addr;

	assign len        = word[LEN_W-1:0];
	assign w_chan     = word[CHAN_LSB +: CHAN_W];
	assign w_val      = word[VAL_W-1:0];
	assign w_is_hit   = (word[TAG_LSB +: TAG_W] == '0);
	assign w_in_range = (32'(w_chan) < 32'(NUM_CHANNELS)) && (32'(w_val) < 32'(NUM_BINS));
	assign rd_addr    = HIST_AW'(HIST_AW'(w_chan) * HIST_AW'(NUM_BINS)) + HIST_AW'(w_val);

	// next control state and stage 1 contents
	phase_t             phase_d;
	logic [LEN_W-1:0]   words_left_d;
	logic [CNT_W-1:0]   mult_d;
	logic [TOTAL_W-1:0] broken_d;
	word_kind_t         kind_d;
	logic [CHAN_W-1:0]  chan_d;
	logic [VAL_W-1:0]   val_d;
	logic [SLOT_W-1:0]  slot_d;
	logic               done_d;
	logic               upd_d;

	always_comb begin
		phase_d      = phase_q;
		words_left_d = words_left_q;
		mult_d       = mult_q;
		broken_d     = broken_q;
		kind_d       = KIND_BLOCK_HDR;
		chan_d       = '0;
		val_d        = '0;
		slot_d       = '0;
		done_d       = 1'b0;
		upd_d        = 1'b0;
		case (phase_q)
			PH_BLOCK: begin
				mult_d = '0;
				if (len > LEN_W'(1)) begin
					words_left_d = len - LEN_W'(1);
					phase_d      = PH_MODULE;
				end else if (len == LEN_W'(1)) begin
					words_left_d = '0;
					phase_d      = PH_BROKEN;
				end else begin
					words_left_d = '0;
					done_d       = 1'b1;
				end
			end
			PH_MODULE: begin
				kind_d  = KIND_MODULE_HDR;
				phase_d = PH_DATA;
			end
			PH_BROKEN: begin
				kind_d  = KIND_BROKEN;
				if (broken_q != '1)
					broken_d = broken_q + TOTAL_W'(1);
				phase_d = PH_BLOCK;
				done_d  = 1'b1;
			end
			default: begin
				if (w_is_hit) begin
					kind_d = KIND_HIT;
					chan_d = w_chan;
					val_d  = w_val;
					slot_d = SLOT_W'(mult_q);
					upd_d  = w_in_range;
					// list full: stay on the last slot
					if (mult_q != CNT_MAX)
						mult_d = mult_q + CNT_W'(1);
				end else begin
					kind_d = KIND_NON_HIT;
				end
				if (words_left_q != '0)
					words_left_d = words_left_q - LEN_W'(1);
				if (words_left_d == '0) begin
					phase_d = PH_BLOCK;
					done_d  = 1'b1;
				end
			end
		endcase
	end

	// bin increment, saturating, with the write-back just missed by the read
	logic [BIN_COUNT_WIDTH-1:0] bin_cur;
	logic [BIN_COUNT_WIDTH-1:0] bin_new;

	assign bin_cur = fwd_s1 ? fwd_data_s1 : rd_data_s1;
	assign bin_new = (bin_cur == BIN_MAX) ? bin_cur : bin_cur + BIN_COUNT_WIDTH'(1);

	// control state and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_BLOCK;
			words_left_q <= '0;
			mult_q       <= '0;
			broken_q     <= '0;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else begin
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + HIST_AW'(1);
				if (clr_addr_q == CLR_LAST)
					clr_active_q <= 1'b0;
			end
			if (accept) begin
				phase_q      <= phase_d;
				words_left_q <= words_left_d;
				mult_q       <= mult_d;
				broken_q     <= broken_d;
			end
		end
	end

	// histogram read port
	always_ff @(posedge clk) begin
		if (accept)
			rd_data_s1 <= hist_mem[rd_addr];
	end

	// histogram write port: clearing pass or write-back
	always_ff @(posedge clk) begin
		if (clr_active_q)
			hist_mem[clr_addr_q] <= '0;
		else if (adv_s1 && upd_s1)
			hist_mem[addr_s1] <= bin_new;
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= kind_d;
			chan_s1     <= chan_d;
			val_s1      <= val_d;
			slot_s1     <= slot_d;
			cnt_s1      <= SLOT_W'(mult_d);
			broken_s1   <= broken_d;
			done_s1     <= done_d;
			upd_s1      <= upd_d;
			addr_s1     <= rd_addr;
			fwd_s1      <= adv_s1 && upd_s1 && (addr_s1 == rd_addr);
			fwd_data_s1 <= bin_new;
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s2   <= kind_s1;
			chan_s2   <= chan_s1;
			val_s2    <= val_s1;
			slot_s2   <= slot_s1;
			cnt_s2    <= cnt_s1;
			bin_s2    <= upd_s1 ? 32'(bin_new) : '0;
			broken_s2 <= broken_s1;
			done_s2   <= done_s1;
		end
	end

	assign res_valid    = valid_s2;
	assign word_kind    = kind_s2;
	assign hit_channel  = chan_s2;
	assign hit_value    = val_s2;
	assign hit_slot     = slot_s2;
	assign hit_count    = cnt_s2;
	assign bin_count    = bin_s2;
	assign broken_total = broken_s2;
	assign event_done   = done_s2;

	// no request taken while the histogram is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !word_ready)
		else $error("request accepted during histogram clear");

	// multiplicity never passes the last list slot
	a_mult_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mult_q <= CNT_MAX)
		else $error("hit multiplicity beyond list");

	// a written-back bin never wraps to zero
	a_bin_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && upd_s1) |-> (bin_new != '0))
		else $error("histogram bin wrapped");

	// a broken word always closes its event
	a_broken_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 == KIND_BROKEN) |-> done_s2)
		else $error("broken word did not end event");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import adcevu_pkg::*;

	localparam int unsigned HIT_SLOTS = MAX_HITS_DEF;
	localparam int unsigned BIN_TOTAL = NUM_CHANNELS_DEF * NUM_BINS_DEF;
	localparam int unsigned RANDOM_WORDS = 1250;
	localparam int unsigned HOLD_AFTER = 400;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam longint unsigned RUN_LIMIT_NS = 64'd40_000_000;

	typedef enum logic [1:0] {
		EXP_BLOCK_HDR,
		EXP_MODULE_HDR,
		EXP_DATA,
		EXP_BROKEN
	} readout_phase_t;

	typedef struct packed {
		word_kind_t  kind;
		logic [3:0]  channel;
		logic [11:0] value;
		logic [5:0]  slot;
		logic [5:0]  count;
		logic [31:0] bin;
		logic [31:0] broken;
		logic        done;
	} unpacked_word_t;

	logic        clk;
	logic        arst_n;
	logic        word_valid;
	logic        word_ready;
	logic [31:0] word;
	logic        res_valid;
	logic        res_ready;
	logic [2:0]  word_kind;
	logic [3:0]  hit_channel;
	logic [11:0] hit_value;
	logic [5:0]  hit_slot;
	logic [5:0]  hit_count;
	logic [31:0] bin_count;
	logic [31:0] broken_total;
	logic        event_done;

	// pending readout words and the results they should produce
	logic [31:0]    word_q[$];
	unpacked_word_t unpacked_q[$];

	// predictor state
	readout_phase_t rd_phase;
	logic [12:0]    rd_words_left;
	int unsigned    rd_mult;
	logic [31:0]    rd_broken;
	logic [31:0]    hist_bins [0:BIN_TOTAL-1];

	// handshake bookkeeping
	bit          word_taken;
	bit          res_taken;
	int          src_gap, src_burst;
	int          sink_gap, sink_burst;
	int          hold_left;
	bit          held;
	int unsigned results_seen;
	int unsigned err_cnt;

	// run statistics
	int unsigned n_events, n_hits, n_full_hits, n_non_hits, n_broken, n_cut;

	adc_event_word_unpacker DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.word_valid  (word_valid),
		.word_ready  (word_ready),
		.word        (word),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.word_kind   (word_kind),
		.hit_channel (hit_channel),
		.hit_value   (hit_value),
		.hit_slot    (hit_slot),
		.hit_count   (hit_count),
		.bin_count   (bin_count),
		.broken_total(broken_total),
		.event_done  (event_done)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long, with idle-free bursts
	function automatic int gap_len(inout int burst_left);
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// predict the result of one accepted readout word
	task automatic unpack_word(input logic [31:0] w);
		unpacked_word_t res;
		logic [3:0]     ch;
		logic [11:0]    val;
		int unsigned    slot;
		int unsigned    idx;
		res = '0;
		case (rd_phase)
			EXP_BLOCK_HDR: begin
				res.kind = KIND_BLOCK_HDR;
				rd_mult = 0;
				n_events++;
				if (w[12:0] > 13'd1) begin
					rd_words_left = w[12:0] - 13'd1;
					rd_phase = EXP_MODULE_HDR;
				end else if (w[12:0] == 13'd1) begin
					rd_words_left = '0;
					rd_phase = EXP_BROKEN;
				end else begin
					rd_words_left = '0;
					res.done = 1'b1;
				end
			end
			EXP_MODULE_HDR: begin
				res.kind = KIND_MODULE_HDR;
				rd_phase = EXP_DATA;
			end
			EXP_BROKEN: begin
				res.kind = KIND_BROKEN;
				if (rd_broken != '1)
					rd_broken++;
				rd_phase = EXP_BLOCK_HDR;
				res.done = 1'b1;
				n_broken++;
			end
			default: begin
				if (w[26:21] == 6'd0) begin
					ch = w[20:17];
					val = w[11:0];
					slot = (rd_mult >= HIT_SLOTS) ? HIT_SLOTS - 1 : rd_mult;
					// every channel and value fits the histogram at these sizes
					idx = 32'({ch, val});
					if (hist_bins[idx] != '1)
						hist_bins[idx]++;
					res.bin = hist_bins[idx];
					rd_mult = (slot + 1 > HIT_SLOTS - 1) ? HIT_SLOTS - 1 : slot + 1;
					res.kind = KIND_HIT;
					res.channel = ch;
					res.value = val;
					res.slot = slot[5:0];
					n_hits++;
					if (slot == HIT_SLOTS - 1)
						n_full_hits++;
				end else begin
					res.kind = KIND_NON_HIT;
					n_non_hits++;
				end
				if (rd_words_left > 0)
					rd_words_left--;
				if (rd_words_left == 0) begin
					rd_phase = EXP_BLOCK_HDR;
					res.done = 1'b1;
				end
			end
		endcase
		res.count = rd_mult[5:0];
		res.broken = rd_broken;
		unpacked_q.push_back(res);
	endtask

	// one event: header of the given length, then the first 'sent' words that follow it
	task automatic queue_event(input int len, input int sent, input int hit_pct);
		logic [31:0] r;
		logic [3:0]  ch;
		logic [11:0] val;
		int          i;
		r = $urandom;
		word_q.push_back({r[31:13], len[12:0]});
		for (i = 0; i < sent; i++) begin
			r = $urandom;
			if (len == 1 || i == 0) begin
				word_q.push_back(r);
			end else if ($urandom_range(0, 99) < hit_pct) begin
				// a few hot bins so that one bin is hit back to back
				if ($urandom_range(0, 99) < 30) begin
					ch = 4'($urandom_range(0, 1));
					val = 12'($urandom_range(0, 3));
				end else begin
					ch = 4'($urandom);
					val = 12'($urandom);
				end
				word_q.push_back({r[31:27], 6'd0, ch, r[16:12], val});
			end else begin
				word_q.push_back({r[31:27], 6'($urandom_range(1, 63)), r[20:0]});
			end
		end
	endtask

	// compare one result field against the prediction
	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			err_cnt++;
		end
	endfunction

	// request side: note each accepted word and predict its result
	always @(posedge clk) begin
		if (arst_n && word_valid && word_ready) begin
			unpack_word(word);
			word_taken = 1'b1;
		end
	end

	// request driver, fed from the pending word queue
	always @(negedge clk) begin
		if (arst_n) begin
			if (!word_valid || word_taken) begin
				if (word_taken)
					src_gap = gap_len(src_burst);
				if (src_gap > 0) begin
					src_gap--;
					word_valid <= 1'b0;
				end else if (word_q.size() > 0) begin
					word <= word_q.pop_front();
					word_valid <= 1'b1;
				end else begin
					word_valid <= 1'b0;
				end
			end
			word_taken = 1'b0;
		end
	end

	// result receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (arst_n) begin
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (res_taken)
				sink_gap = gap_len(sink_burst);
			res_taken = 1'b0;
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		unpacked_word_t exp_r;
		if (arst_n && res_valid && res_ready) begin
			res_taken = 1'b1;
			results_seen++;
			if (unpacked_q.size() == 0) begin
				$error("result with no word outstanding: kind %0d", word_kind);
				err_cnt++;
			end else begin
				exp_r = unpacked_q.pop_front();
				check_field("word_kind", 32'(exp_r.kind), 32'(word_kind));
				check_field("hit_channel", 32'(exp_r.channel), 32'(hit_channel));
				check_field("hit_value", 32'(exp_r.value), 32'(hit_value));
				check_field("hit_slot", 32'(exp_r.slot), 32'(hit_slot));
				check_field("hit_count", 32'(exp_r.count), 32'(hit_count));
				check_field("bin_count", exp_r.bin, bin_count);
				check_field("broken_total", exp_r.broken, broken_total);
				check_field("event_done", 32'(exp_r.done), 32'(event_done));
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int i;
		int r;
		int len;
		bit long_done;
		arst_n = 1'b0;
		word_valid = 1'b0;
		word = '0;
		res_ready = 1'b0;
		rd_phase = EXP_BLOCK_HDR;
		rd_words_left = '0;
		rd_mult = 0;
		rd_broken = '0;
		long_done = 1'b0;
		for (i = 0; i < BIN_TOTAL; i++)
			hist_bins[i] = '0;

		// directed: empty events, broken events, field extremes, one bin twice in a row
		word_q.push_back(32'h0000_0000);
		word_q.push_back(32'hFFFF_E000);
		word_q.push_back(32'h0000_0001);
		word_q.push_back(32'hFFFF_FFFF);
		word_q.push_back(32'hFFFF_E001);
		word_q.push_back(32'h0000_0000);
		word_q.push_back(32'h0000_0002);
		word_q.push_back(32'hFFFF_FFFF);
		word_q.push_back(32'h0000_0000);
		word_q.push_back(32'hA5A5_A005);
		word_q.push_back(32'h0000_0000);
		word_q.push_back(32'hF81F_FFFF);
		word_q.push_back(32'hF81F_FFFF);
		word_q.push_back(32'hFFFF_FFFF);
		word_q.push_back(32'h0020_0000);
		word_q.push_back(32'h0000_0004);
		word_q.push_back(32'h1234_5678);
		word_q.push_back(32'h07E0_0000);
		word_q.push_back(32'h0001_E800);
		word_q.push_back(32'h0000_0FFF);

		// random: mostly well-formed events, some empty, broken, cut short or very full
		while (word_q.size() < 20 + RANDOM_WORDS) begin
			r = $urandom_range(0, 99);
			if (!long_done && word_q.size() > 20 + RANDOM_WORDS - 120) begin
				// length above 4095 so the top length bit is used; the stream ends inside it
				long_done = 1'b1;
				queue_event(4100, 100, 85);
			end else if (r < 5) begin
				queue_event(0, 0, 0);
			end else if (r < 10) begin
				queue_event(1, 1, 0);
			end else if (r < 15) begin
				len = $urandom_range(2, 20);
				n_cut++;
				queue_event(len, $urandom_range(0, len - 1), 70);
			end else if (r < 21) begin
				len = $urandom_range(40, 70);
				queue_event(len, len, $urandom_range(80, 100));
			end else begin
				len = $urandom_range(2, 12);
				queue_event(len, len, $urandom_range(50, 100));
			end
		end

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		while (word_q.size() != 0 || word_valid)
			@(posedge clk);
		while (unpacked_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results over %0d events: %0d hits (%0d on the last slot),",
			results_seen, n_events, n_hits, n_full_hits);
		$display("%0d non-hit words, %0d broken events, %0d events cut short.",
			n_non_hits, n_broken, n_cut);
		if (err_cnt == 0 && unpacked_q.size() == 0) begin
			$display("PASS adc_event_word_unpacker");
		end else begin
			$display("FAIL adc_event_word_unpacker");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(RUN_LIMIT_NS);
		$display("FAIL adc_event_word_unpacker");
		$finish;
	end

endmodule

// File: filelist.f
rtl/adcevu_pkg.sv
rtl/adc_event_word_unpacker.sv
dv/tb.sv
